// ===== rtl/core/irc_format_attribute_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// irc_format_attribute_decoder_assert
// Assertion macros used by the formatting-code decoder top level.
// ----------------------------------------------------------------------------
`ifndef IRC_FORMAT_ATTRIBUTE_DECODER_ASSERT_SVH
`define IRC_FORMAT_ATTRIBUTE_DECODER_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define IRC_FAD_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define IRC_FAD_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/irc_fad_pkg.sv =====
// ----------------------------------------------------------------------------
// irc_fad_pkg
// Types, codes and the color palette of the formatting-code decoder.
// ----------------------------------------------------------------------------
package irc_fad_pkg;

  localparam int RGB_W   = 24;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 7;
  localparam int IDX_W   = 4;
  localparam int PHASE_W = 3;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BG = 1'b1;

  localparam logic [RGB_W-1:0] DEFAULT_FG_RESET = 24'h000000;
  localparam logic [RGB_W-1:0] DEFAULT_BG_RESET = 24'hFFFFFF;

  // Color spec phases
  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FG0  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_FG1  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FG2  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_BG0  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_BG1  = 3'd5;

  // Control bytes
  localparam logic [CHAR_W-1:0] CH_BOLD      = 8'd2;
  localparam logic [CHAR_W-1:0] CH_COLOR     = 8'd3;
  localparam logic [CHAR_W-1:0] CH_PLAIN     = 8'd15;
  localparam logic [CHAR_W-1:0] CH_REVERSE   = 8'd22;
  localparam logic [CHAR_W-1:0] CH_UNDERLINE = 8'd31;
  localparam logic [CHAR_W-1:0] CH_COMMA     = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;

  // Input stage contents
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] byte_val;
    logic              last;
  } in_beat_t;

  // Display attribute state
  typedef struct packed {
    logic               bold_on;
    logic               underline_on;
    logic               reverse_on;
    logic               fg_chosen;
    logic               bg_chosen;
    logic [IDX_W-1:0]   chosen_fg_index;
    logic [IDX_W-1:0]   chosen_bg_index;
    logic [RGB_W-1:0]   shown_fg;
    logic [RGB_W-1:0]   shown_bg;
    logic               shown_bg_valid;
    logic [PHASE_W-1:0] spec_phase;
    logic [DIGIT_W-1:0] fg_digits;
    logic [DIGIT_W-1:0] bg_digits;
  } attr_state_t;

  // One decoded character beat
  typedef struct packed {
    logic [CHAR_W-1:0] char_val;
    logic [RGB_W-1:0]  fg;
    logic [RGB_W-1:0]  bg;
    logic              bg_present;
    logic              bold;
    logic              underline;
  } char_beat_t;

  localparam attr_state_t ST_RESET = '{
    bold_on:         1'b0,
    underline_on:    1'b0,
    reverse_on:      1'b0,
    fg_chosen:       1'b0,
    bg_chosen:       1'b0,
    chosen_fg_index: '0,
    chosen_bg_index: '0,
    shown_fg:        DEFAULT_FG_RESET,
    shown_bg:        '0,
    shown_bg_valid:  1'b0,
    spec_phase:      PH_IDLE,
    fg_digits:       '0,
    bg_digits:       '0
  };

  // 16-entry color palette
  function automatic logic [RGB_W-1:0] palette(input logic [IDX_W-1:0] idx);
    logic [RGB_W-1:0] rgb;
    case (idx)
      4'd0:    rgb = 24'hFFFFFF;
      4'd1:    rgb = 24'h000000;
      4'd2:    rgb = 24'h000080;
      4'd3:    rgb = 24'h008000;
      4'd4:    rgb = 24'hFF0000;
      4'd5:    rgb = 24'h800000;
      4'd6:    rgb = 24'h800080;
      4'd7:    rgb = 24'hFFA500;
      4'd8:    rgb = 24'hFFFF00;
      4'd9:    rgb = 24'h00FF00;
      4'd10:   rgb = 24'h008080;
      4'd11:   rgb = 24'h00FFFF;
      4'd12:   rgb = 24'h0000FF;
      4'd13:   rgb = 24'hFF00FF;
      4'd14:   rgb = 24'h808080;
      4'd15:   rgb = 24'hC0C0C0;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

// ===== rtl/core/irc_fad_in_reg.sv =====
// ----------------------------------------------------------------------------
// irc_fad_in_reg
// Input register: captures one byte beat and holds it until decoded.
// ----------------------------------------------------------------------------
module irc_fad_in_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [irc_fad_pkg::CHAR_W-1:0] byte_in,
  input  logic                         last,
  input  logic                         adv,
  output irc_fad_pkg::in_beat_t        beat
);
  import irc_fad_pkg::*;

  // Stage is free when empty or when its beat moves on this cycle
  assign in_stall = beat.valid && !adv;

  // Valid flag and payload of the held beat
  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (!in_stall) begin
      beat.valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      beat.byte_val <= byte_in;
      beat.last     <= last;
    end
  end

endmodule

// ===== rtl/core/irc_fad_core.sv =====
// ----------------------------------------------------------------------------
// irc_fad_core
// Attribute state, default color registers and the one-byte decode step.
// ----------------------------------------------------------------------------
module irc_fad_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [irc_fad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irc_fad_pkg::RGB_W-1:0]      cfg_data,
  input  logic                               adv,
  input  irc_fad_pkg::in_beat_t              beat,
  output logic                               emit,
  output irc_fad_pkg::char_beat_t            res
);
  import irc_fad_pkg::*;

  logic [RGB_W-1:0] default_fg;
  logic [RGB_W-1:0] default_bg;
  attr_state_t      st;
  attr_state_t      st_next;

  logic [CHAR_W-1:0] b;
  logic              is_dig;
  logic              is_comma;
  logic [IDX_W-1:0]  d;
  logic              consumed;
  logic              do_apply;
  logic              have_fg;
  logic              have_bg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_fg <= DEFAULT_FG_RESET;
      default_bg <= DEFAULT_BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT_FG: default_fg <= cfg_data;
        REG_DEFAULT_BG: default_bg <= cfg_data;
        default: ;
      endcase
    end
  end

  assign b        = beat.byte_val;
  assign is_dig   = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_comma = (b == CH_COMMA);
  assign d        = b[IDX_W-1:0];

  // Decode step: open spec first, then control codes, then end of message
  always_comb begin
    st_next  = st;
    consumed = 1'b0;
    do_apply = 1'b0;
    have_fg  = 1'b0;
    have_bg  = 1'b0;
    emit     = 1'b0;

    // Feed an open color spec
    if (st.spec_phase != PH_IDLE) begin
      case (st.spec_phase)
        PH_FG0: begin
          if (is_dig) begin
            st_next.fg_digits  = {3'b000, d};
            st_next.spec_phase = PH_FG1;
            consumed = 1'b1;
          end
        end
        PH_FG1: begin
          if (is_dig) begin
            st_next.fg_digits  = st.fg_digits * 7'd10 + {3'b000, d};
            st_next.spec_phase = PH_FG2;
            consumed = 1'b1;
          end else if (is_comma) begin
            st_next.spec_phase = PH_BG0;
            consumed = 1'b1;
          end
        end
        PH_FG2: begin
          if (is_comma) begin
            st_next.spec_phase = PH_BG0;
            consumed = 1'b1;
          end
        end
        PH_BG0: begin
          if (is_dig) begin
            st_next.bg_digits  = {3'b000, d};
            st_next.spec_phase = PH_BG1;
            consumed = 1'b1;
          end
        end
        PH_BG1: begin
          if (is_dig) begin
            st_next.bg_digits  = st.bg_digits * 7'd10 + {3'b000, d};
            st_next.spec_phase = PH_IDLE;
            consumed = 1'b1;
            do_apply = 1'b1;
          end
        end
        default: ;
      endcase
      if (!consumed) begin
        do_apply = 1'b1;
      end
    end

    // Apply a finished spec; idle phase here means both bg digits came in
    if (do_apply) begin
      have_fg = (st_next.spec_phase != PH_FG0);
      have_bg = (st_next.spec_phase == PH_BG1) || (st_next.spec_phase == PH_IDLE);
      if (have_fg) begin
        if (st_next.fg_digits < 7'd16) begin
          st_next.fg_chosen       = 1'b1;
          st_next.chosen_fg_index = st_next.fg_digits[IDX_W-1:0];
          st_next.shown_fg        = palette(st_next.fg_digits[IDX_W-1:0]);
        end
      end else begin
        st_next.fg_chosen      = 1'b0;
        st_next.bg_chosen      = 1'b0;
        st_next.shown_fg       = default_fg;
        st_next.shown_bg       = '0;
        st_next.shown_bg_valid = 1'b0;
      end
      if (have_bg && (st_next.bg_digits < 7'd16)) begin
        st_next.bg_chosen       = 1'b1;
        st_next.chosen_bg_index = st_next.bg_digits[IDX_W-1:0];
        st_next.shown_bg        = palette(st_next.bg_digits[IDX_W-1:0]);
        st_next.shown_bg_valid  = 1'b1;
      end
      st_next.spec_phase = PH_IDLE;
      st_next.fg_digits  = '0;
      st_next.bg_digits  = '0;
    end

    // Control codes and printable bytes
    if (!consumed) begin
      case (b)
        CH_BOLD: st_next.bold_on = !st_next.bold_on;
        CH_PLAIN: begin
          st_next.shown_fg       = default_fg;
          st_next.shown_bg       = '0;
          st_next.shown_bg_valid = 1'b0;
          st_next.bold_on        = 1'b0;
          st_next.underline_on   = 1'b0;
          st_next.reverse_on     = 1'b0;
          st_next.fg_chosen      = 1'b0;
          st_next.bg_chosen      = 1'b0;
        end
        CH_REVERSE: begin
          if (!st_next.reverse_on) begin
            st_next.reverse_on     = 1'b1;
            st_next.shown_fg       = default_bg;
            st_next.shown_bg       = default_fg;
            st_next.shown_bg_valid = 1'b1;
          end else begin
            st_next.reverse_on = 1'b0;
            st_next.shown_fg   = st_next.fg_chosen ? palette(st_next.chosen_fg_index)
                                                   : default_fg;
            if (st_next.bg_chosen) begin
              st_next.shown_bg       = palette(st_next.chosen_bg_index);
              st_next.shown_bg_valid = 1'b1;
            end else begin
              st_next.shown_bg       = '0;
              st_next.shown_bg_valid = 1'b0;
            end
          end
        end
        CH_UNDERLINE: st_next.underline_on = !st_next.underline_on;
        CH_COLOR: begin
          // Color codes are dropped while reverse is on
          if (!st_next.reverse_on) begin
            st_next.spec_phase = PH_FG0;
            st_next.fg_digits  = '0;
            st_next.bg_digits  = '0;
          end
        end
        default: emit = 1'b1;
      endcase
    end

    // Character beat from the attributes in force
    res.char_val   = b;
    res.fg         = st_next.shown_fg;
    res.bg         = st_next.shown_bg_valid ? st_next.shown_bg : '0;
    res.bg_present = st_next.shown_bg_valid;
    res.bold       = st_next.bold_on;
    res.underline  = st_next.underline_on;

    // End of message clears the attribute state
    if (beat.last) begin
      st_next          = ST_RESET;
      st_next.shown_fg = default_fg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (adv) begin
      st <= st_next;
    end
  end

endmodule

// ===== rtl/core/irc_format_attribute_decoder.sv =====
// ----------------------------------------------------------------------------
// irc_format_attribute_decoder
// Chat text formatting-code decoder: bytes in, attributed characters out.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle and keeps the bold, underline, reverse and
// color state of the text. Every byte that is not a control code or part of a
// color spec comes out as one beat with its colors and attributes; control
// bytes produce no beat. A byte is held in the input register and decoded in a
// single pass into the output register, which presents the beat; a new byte is
// taken every cycle unless the output register holds a beat that is stalled.
// The default colors are to be written through the configuration port only
// while no bytes are in flight; the block itself does not enforce this.
`include "irc_format_attribute_decoder_assert.svh"

module irc_format_attribute_decoder (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration
  input  logic                               cfg_we,
  input  logic [irc_fad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irc_fad_pkg::RGB_W-1:0]      cfg_data,
  // Byte input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [irc_fad_pkg::CHAR_W-1:0]     byte_in,
  input  logic                               last,
  // Character output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [irc_fad_pkg::CHAR_W-1:0]     char_out,
  output logic [irc_fad_pkg::RGB_W-1:0]      fg_rgb,
  output logic [irc_fad_pkg::RGB_W-1:0]      bg_rgb,
  output logic                               bg_present,
  output logic                               is_bold,
  output logic                               is_underlined
);
  import irc_fad_pkg::*;

  in_beat_t   beat;
  char_beat_t res;
  char_beat_t out_q;
  logic       emit;
  logic       adv;

  // Decode moves on when the output register can take a beat
  assign adv = beat.valid && (!out_valid || !out_stall);

  irc_fad_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .byte_in  (byte_in),
    .last     (last),
    .adv      (adv),
    .beat     (beat)
  );

  irc_fad_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (adv),
    .beat      (beat),
    .emit      (emit),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_q <= res;
    end
  end

  assign char_out      = out_q.char_val;
  assign fg_rgb        = out_q.fg;
  assign bg_rgb        = out_q.bg;
  assign bg_present    = out_q.bg_present;
  assign is_bold       = out_q.bold;
  assign is_underlined = out_q.underline;

  // Checks
  `IRC_FAD_ASSERT_NOW(a_bg_cleared, clk, rst, out_valid && !bg_present, bg_rgb == '0,
    "background color set while no background applies")
  `IRC_FAD_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall,
    "input stalled while the output register is free")
  `IRC_FAD_ASSERT_NEXT(a_no_phantom, clk, rst, !out_valid && !adv, !out_valid,
    "output beat appeared without a decoded byte")

endmodule
